>>> rtl/lie_pkg.sv
// ----------------------------------------------------------------------------
// lie_pkg: shared types and constants for the Lagrange interpolation evaluator
// Payload structs, controller/datapath command and status groups, codes.
// ----------------------------------------------------------------------------
package lie_pkg;

  localparam int MAX_NODES = 64;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = 7;                  // node_count register width
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;         // x differences
  localparam int DVD_W     = DIFF_W + FRAC_BITS; // shifted numerator magnitude
  localparam int ACC_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_SELECT = 1'd1;

  typedef struct packed {
    logic                     req_type;
    logic [ADDR_W-1:0]        node_index;
    logic signed [DATA_W-1:0] node_x;
    logic signed [DATA_W-1:0] node_y_first;
    logic signed [DATA_W-1:0] node_y_second;
    logic signed [DATA_W-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic [1:0]               eval_status;
  } out_item_t;

  typedef struct packed {
    logic              start;      // evaluate accepted: clear sum and flags
    logic              wr_en;      // load accepted
    logic [ADDR_W-1:0] rd_addr;
    logic              latch_xi;
    logic              term_init;  // latch x_i, y_i, basis = 1.0
    logic              dup_set;
    logic              div_start;
    logic              mul_start;
    logic              mul_sel_y;
    logic              basis_upd;
    logic              sum_upd;
    logic              out_load;
    logic              col_sel;
  } lie_cmd_t;

  typedef struct packed {
    logic dup_eq;
    logic div_done;
    logic mul_done;
  } lie_sts_t;

endpackage

>>> rtl/lagrange_interpolation_evaluator.sv
// ----------------------------------------------------------------------------
// lagrange_interpolation_evaluator: fixed-point Lagrange polynomial evaluator
// Loads nodes into a 64-entry table; evaluates the polynomial through the
// first min(node_count, 64) nodes at query_x (signed Q16.16, saturating).
// ----------------------------------------------------------------------------
// Load transaction: writes the node table; no result.
// Evaluate transaction, n = min(node_count, 64): scans the x values for a
//   duplicate, then sums n basis-weighted y terms into the result.
// Each basis factor costs a divide and a multiply; the bit-serial divider
// (one quotient bit a cycle, 49 bits) dominates.
// One evaluation at a time; the next transaction is taken once the result is
// in the output register. Reset: synchronous, active low; config goes to
// node_count = 5, column_select = 0; the node table is not cleared.
// ----------------------------------------------------------------------------
module lagrange_interpolation_evaluator
  import lie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input transactions
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // result transactions
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  lie_cmd_t cmd;
  lie_sts_t sts;

  // controller: config, counters, handshakes
  lie_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_item.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg_ready   (cfg_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath: tables, divider, multiplier, accumulator, output register
  lie_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // a duplicate-node result always carries zero
  a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.eval_status == ST_DUP |-> out_item.interp_value == '0)
    else $error("duplicate result with nonzero value");

  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.eval_status != 2'd3)
    else $error("undefined status code");

  // an evaluate transaction makes the block busy on the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.req_type == REQ_EVAL |=> in_stall)
    else $error("evaluate did not start");

  // a load transaction leaves the block ready on the next cycle
  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.req_type == REQ_LOAD |=> !in_stall)
    else $error("load held the input");

endmodule

>>> rtl/lie_div.sv
// ----------------------------------------------------------------------------
// lie_div: restoring unsigned divider
// One quotient bit per cycle; done pulses once the last bit is in the quotient register.
// ----------------------------------------------------------------------------
module lie_div
  import lie_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIFF_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  localparam int CW = $clog2(DVD_W);
  localparam logic [CW-1:0] LAST = CW'(DVD_W - 1);

  logic [DVD_W-1:0]  q_r;
  logic [DIFF_W-1:0] rem_r;
  logic [DIFF_W-1:0] dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIFF_W:0]   rem_sh;
  logic              ge;
  logic [DIFF_W:0]   rem_sub;

  assign rem_sh  = {rem_r, q_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) busy_r <= 1'b0;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/lie_mul.sv
// ----------------------------------------------------------------------------
// lie_mul: sign-magnitude fixed-point multiplier
// 64x64 magnitude product from four 32x32 partials, then >> FRAC_BITS and
// saturation to 2^63-1.
// ----------------------------------------------------------------------------
module lie_mul
  import lie_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ACC_W-1:0]        a_mag,
  input  logic [ACC_W-1:0]        b_mag,
  input  logic                    neg,
  output logic                    done,
  output logic signed [ACC_W-1:0] res,
  output logic                    sat
);

  localparam int H = ACC_W / 2;
  localparam int P = 2 * ACC_W;

  logic [ACC_W-1:0] a_r, b_r;
  logic             neg_r;
  logic [2:0]       cnt_r;
  logic             busy_r, done_r;
  logic [ACC_W-1:0] pp_r;
  logic [1:0]       pp_sh_r;
  logic [P-1:0]     acc_r;
  logic [H-1:0]     a_sel, b_sel;
  logic [1:0]       sh_sel;
  logic [P-1:0]     pp_ext;
  logic [ACC_W-2:0] mag;

  always_comb begin
    case (cnt_r)
      3'd0:    begin a_sel = a_r[H-1:0];     b_sel = b_r[H-1:0];     sh_sel = 2'd0; end
      3'd1:    begin a_sel = a_r[H-1:0];     b_sel = b_r[ACC_W-1:H]; sh_sel = 2'd1; end
      3'd2:    begin a_sel = a_r[ACC_W-1:H]; b_sel = b_r[H-1:0];     sh_sel = 2'd1; end
      default: begin a_sel = a_r[ACC_W-1:H]; b_sel = b_r[ACC_W-1:H]; sh_sel = 2'd2; end
    endcase
  end

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_ext = {{ACC_W{1'b0}}, pp_r};
      2'd1:    pp_ext = {{H{1'b0}}, pp_r, {H{1'b0}}};
      default: pp_ext = {pp_r, {ACC_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      b_r   <= b_mag;
      neg_r <= neg;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        pp_r    <= a_sel * b_sel;
        pp_sh_r <= sh_sel;
      end
      if (cnt_r != 3'd0) acc_r <= acc_r + pp_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd4);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) busy_r <= 1'b0;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign sat  = |acc_r[P-1:FRAC_BITS+ACC_W-1];
  assign mag  = sat ? {(ACC_W-1){1'b1}} : acc_r[FRAC_BITS+ACC_W-2:FRAC_BITS];
  assign res  = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done = done_r;

endmodule

>>> rtl/lie_dpath.sv
// ----------------------------------------------------------------------------
// lie_dpath: node tables, basis/sum registers, divider, multiplier, output
// Executes controller commands; reports compare and unit completion.
// ----------------------------------------------------------------------------
module lie_dpath
  import lie_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  lie_cmd_t  cmd,
  output lie_sts_t  sts,
  output out_item_t out_item
);

  localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0]   SUM_HI  = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0]   SUM_LO  = -SUM_HI;
  localparam logic signed [ACC_W-1:0] O_HI    =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] O_LO    = -(O_HI + 1);

  logic [DATA_W-1:0] mem_x  [MAX_NODES];
  logic [DATA_W-1:0] mem_y0 [MAX_NODES];
  logic [DATA_W-1:0] mem_y1 [MAX_NODES];
  logic [DATA_W-1:0] rd_x_r, rd_y0_r, rd_y1_r;

  logic signed [DATA_W-1:0] q_r, xi_r, y_r;
  logic signed [ACC_W-1:0]  basis_r, sum_r;
  logic                     fneg_r, sat_r, dup_r;
  out_item_t                out_r;

  logic signed [DIFF_W-1:0] num, den;
  logic [DIFF_W-1:0]        num_mag, den_mag;
  logic                     div_done;
  logic [DVD_W-1:0]         quo;
  logic [ACC_W-1:0]         basis_mag, b_mag;
  logic [DIFF_W-1:0]        y_mag;
  logic                     m_neg, mul_done, mul_sat;
  logic signed [ACC_W-1:0]  mul_res;
  logic signed [ACC_W:0]    sum_ext;
  logic signed [ACC_W-1:0]  sum_nxt;
  logic                     add_sat;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[in_item.node_index]  <= in_item.node_x;
      mem_y0[in_item.node_index] <= in_item.node_y_first;
      mem_y1[in_item.node_index] <= in_item.node_y_second;
    end
    rd_x_r  <= mem_x[cmd.rd_addr];
    rd_y0_r <= mem_y0[cmd.rd_addr];
    rd_y1_r <= mem_y1[cmd.rd_addr];
  end

  assign num     = {q_r[DATA_W-1], q_r} - {rd_x_r[DATA_W-1], rd_x_r};
  assign den     = {xi_r[DATA_W-1], xi_r} - {rd_x_r[DATA_W-1], rd_x_r};
  assign num_mag = num[DIFF_W-1] ? -num : num;
  assign den_mag = den[DIFF_W-1] ? -den : den;

  lie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({num_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (quo)
  );

  assign basis_mag = basis_r[ACC_W-1] ? -basis_r : basis_r;
  assign y_mag     = y_r[DATA_W-1] ? -{y_r[DATA_W-1], y_r} : {1'b0, y_r};
  always_comb begin
    if (cmd.mul_sel_y) begin
      b_mag = ACC_W'(y_mag);
      m_neg = basis_r[ACC_W-1] ^ y_r[DATA_W-1];
    end else begin
      b_mag = ACC_W'(quo);
      m_neg = basis_r[ACC_W-1] ^ fneg_r;
    end
  end

  lie_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (basis_mag),
    .b_mag (b_mag),
    .neg   (m_neg),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  // saturating accumulate
  assign sum_ext = {sum_r[ACC_W-1], sum_r} + {mul_res[ACC_W-1], mul_res};
  always_comb begin
    add_sat = 1'b0;
    sum_nxt = sum_ext[ACC_W-1:0];
    if (sum_ext > SUM_HI) begin
      add_sat = 1'b1;
      sum_nxt = S64_MAX;
    end else if (sum_ext < SUM_LO) begin
      add_sat = 1'b1;
      sum_nxt = -S64_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r   <= in_item.query_x;
      sum_r <= '0;
      sat_r <= 1'b0;
      dup_r <= 1'b0;
    end
    if (cmd.latch_xi || cmd.term_init) xi_r <= rd_x_r;
    if (cmd.term_init) begin
      y_r     <= cmd.col_sel ? rd_y1_r : rd_y0_r;
      basis_r <= ACC_W'(1) <<< FRAC_BITS;
    end
    if (cmd.div_start) fneg_r <= num[DIFF_W-1] ^ den[DIFF_W-1];
    if (cmd.dup_set) dup_r <= 1'b1;
    if (cmd.basis_upd) begin
      basis_r <= mul_res;
      sat_r   <= sat_r | mul_sat;
    end
    if (cmd.sum_upd) begin
      sum_r <= sum_nxt;
      sat_r <= sat_r | mul_sat | add_sat;
    end
    if (cmd.out_load) begin
      if (dup_r) begin
        out_r.interp_value <= '0;
        out_r.eval_status  <= ST_DUP;
      end else if (sum_r > O_HI) begin
        out_r.interp_value <= O_HI[DATA_W-1:0];
        out_r.eval_status  <= ST_SAT;
      end else if (sum_r < O_LO) begin
        out_r.interp_value <= O_LO[DATA_W-1:0];
        out_r.eval_status  <= ST_SAT;
      end else begin
        out_r.interp_value <= sum_r[DATA_W-1:0];
        out_r.eval_status  <= sat_r ? ST_SAT : ST_OK;
      end
    end
  end

  assign sts.dup_eq   = (rd_x_r == xi_r);
  assign sts.div_done = div_done;
  assign sts.mul_done = mul_done;
  assign out_item     = out_r;

endmodule

>>> rtl/lie_ctrl.sv
// ----------------------------------------------------------------------------
// lie_ctrl: sequencer for the Lagrange evaluator
// Holds config, node counters, handshakes; walks the duplicate scan and the
// basis/term loops.
// ----------------------------------------------------------------------------
module lie_ctrl
  import lie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output logic                 cfg_ready,
  input  lie_sts_t             sts,
  output lie_cmd_t             cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_DUP_RI  = 14'b00000000000010,
    S_DUP_RJ  = 14'b00000000000100,
    S_DUP_CMP = 14'b00000000001000,
    S_T_RI    = 14'b00000000010000,
    S_T_LI    = 14'b00000000100000,
    S_T_RJ    = 14'b00000001000000,
    S_T_LJ    = 14'b00000010000000,
    S_T_DIV   = 14'b00000100000000,
    S_MULB_S  = 14'b00001000000000,
    S_MULB    = 14'b00010000000000,
    S_MULY_S  = 14'b00100000000000,
    S_MULY    = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_t;

  localparam logic [CNT_W-1:0] NMAX = CNT_W'(MAX_NODES);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] node_count_r;
  logic             col_sel_r;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] n;
  logic [CNT_W:0]   i1, i2, j1, jn;
  logic             in_acc;

  assign n      = (node_count_r > NMAX) ? NMAX : node_count_r;
  assign i1     = {1'b0, i_r} + 1'b1;
  assign i2     = {1'b0, i_r} + 2'd2;
  assign j1     = {1'b0, j_r} + 1'b1;
  assign jn     = (j1 == {1'b0, i_r}) ? {1'b0, j_r} + 2'd2 : j1;
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.col_sel   = col_sel_r;
    cmd.rd_addr   = j_r[ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            i_nxt     = '0;
            j_nxt     = CNT_W'(1);
            if (n == '0)                state_nxt = S_FIN;
            else if (n == CNT_W'(1))    state_nxt = S_T_RI;
            else                        state_nxt = S_DUP_RI;
          end
        end
      end
      S_DUP_RI: begin
        cmd.rd_addr = i_r[ADDR_W-1:0];
        state_nxt   = S_DUP_RJ;
      end
      S_DUP_RJ: begin
        cmd.latch_xi = 1'b1;
        state_nxt    = S_DUP_CMP;
      end
      S_DUP_CMP: begin
        if (sts.dup_eq) begin
          cmd.dup_set = 1'b1;
          state_nxt   = S_FIN;
        end else if (j1 < {1'b0, n}) begin
          // fetch the next x_j while x_i stays latched
          cmd.rd_addr = j1[ADDR_W-1:0];
          j_nxt       = j1[CNT_W-1:0];
          state_nxt   = S_DUP_CMP;
        end else if (i2 < {1'b0, n}) begin
          i_nxt     = i1[CNT_W-1:0];
          j_nxt     = i2[CNT_W-1:0];
          state_nxt = S_DUP_RI;
        end else begin
          i_nxt     = '0;
          state_nxt = S_T_RI;
        end
      end
      S_T_RI: begin
        cmd.rd_addr = i_r[ADDR_W-1:0];
        state_nxt   = S_T_LI;
      end
      S_T_LI: begin
        cmd.term_init = 1'b1;
        j_nxt         = (i_r == '0) ? CNT_W'(1) : '0;
        if (i_r == '0 && n == CNT_W'(1)) state_nxt = S_MULY_S;
        else                             state_nxt = S_T_RJ;
      end
      S_T_RJ: state_nxt = S_T_LJ;
      S_T_LJ: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_T_DIV;
      end
      S_T_DIV: if (sts.div_done) state_nxt = S_MULB_S;
      S_MULB_S: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MULB;
      end
      S_MULB: begin
        if (sts.mul_done) begin
          cmd.basis_upd = 1'b1;
          j_nxt         = jn[CNT_W-1:0];
          state_nxt     = (jn < {1'b0, n}) ? S_T_RJ : S_MULY_S;
        end
      end
      S_MULY_S: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel_y = 1'b1;
        state_nxt     = S_MULY;
      end
      S_MULY: begin
        cmd.mul_sel_y = 1'b1;
        if (sts.mul_done) begin
          cmd.sum_upd = 1'b1;
          i_nxt       = i1[CNT_W-1:0];
          state_nxt   = (i1 < {1'b0, n}) ? S_T_RI : S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= CNT_W'(5);
      col_sel_r    <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_NODE_COUNT:    node_count_r <= cfg_wdata[CNT_W-1:0];
          REG_COLUMN_SELECT: col_sel_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule
